// ===== rtl/core/delayed_task_timer_queue_unit_defines.svh =====
// assertion macros for the delayed task timer queue
// used by the top level only, needs clk and rst_n in scope
`ifndef DELAYED_TASK_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DELAYED_TASK_TIMER_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define DTTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dttq_pkg.sv =====
// types, codes and sizes for the delayed task timer queue
// no dependencies
package dttq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_W    = 8;
  localparam int TIME_W      = 32;
  localparam int SEQ_W       = 32;

  localparam logic CMD_POST = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  localparam logic STATUS_RELEASED = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef struct packed {
    logic                command;
    logic [TIME_W-1:0]   now_ms;
    logic [TIME_W-1:0]   delay_ms;
    logic [HANDLE_W-1:0] task_handle;
  } in_req_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] released_handle;
    logic [SEQ_W-1:0]    released_seq;
    logic                last;
  } out_rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0]   due;
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } slot_t;

  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t new_entry;
  } chain_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_POLL
  } state_t;

endpackage

// ===== rtl/core/delayed_task_timer_queue_unit.sv =====
// a post is written into the cell chain; a poll releases due tasks one at a time and gives no result if none is due
// a rejected post shows its result in the cycle after it is taken
// release rate is one task per cycle while results are accepted, set by the pop shift of the cell chain
// new requests are held off while a poll is releasing tasks or a result waits on out_ready
// reset (rst_n, synchronous) empties the chain and zeroes the sequence counter
module delayed_task_timer_queue_unit import dttq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

`include "delayed_task_timer_queue_unit_defines.svh"

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_rsp_r, out_rsp_nxt;

  chain_ctl_t        ctl;
  slot_t             head, second;
  logic              full;
  logic              slot_free;
  logic              accept;
  logic [TIME_W:0]   due_sum;
  logic              head_due;
  logic              second_due;

  dttq_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .head   (head),
    .second (second),
    .full   (full)
  );

  assign due_sum    = {1'b0, in_req.now_ms} + {1'b0, in_req.delay_ms};
  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE) && slot_free;
  assign accept     = in_valid && in_ready;
  assign head_due   = head.valid && (head.data.due <= now_r);
  assign second_due = second.valid && (second.data.due <= now_r);

  always_comb begin
    state_nxt           = state_r;
    now_nxt             = now_r;
    seq_nxt             = seq_r;
    out_rsp_nxt         = out_rsp_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    ctl.insert          = 1'b0;
    ctl.pop             = 1'b0;
    ctl.new_entry.due   = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
    ctl.new_entry.seq   = seq_r;
    ctl.new_entry.handle = in_req.task_handle;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.command == CMD_POLL) begin
            now_nxt   = in_req.now_ms;
            state_nxt = ST_POLL;
          end else if (full) begin
            out_valid_nxt               = 1'b1;
            out_rsp_nxt.status          = STATUS_REJECTED;
            out_rsp_nxt.released_handle = in_req.task_handle;
            out_rsp_nxt.released_seq    = '0;
            out_rsp_nxt.last            = 1'b1;
          end else begin
            ctl.insert = 1'b1;
            seq_nxt    = seq_r + 1'b1;
          end
        end
      end
      ST_POLL: begin
        if (!head_due) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          ctl.pop                     = 1'b1;
          out_valid_nxt               = 1'b1;
          out_rsp_nxt.status          = STATUS_RELEASED;
          out_rsp_nxt.released_handle = head.data.handle;
          out_rsp_nxt.released_seq    = head.data.seq;
          out_rsp_nxt.last            = !second_due;
          if (!second_due) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `DTTQ_ASSERT_NOW(a_pop_only_due, ctl.pop, head.valid && (head.data.due <= now_r) && (state_r == ST_POLL), "pop of a task not yet due")
  `DTTQ_ASSERT_NEXT(a_reject_full, accept && (in_req.command == CMD_POST) && full, out_valid && (out_rsp.status == STATUS_REJECTED) && out_rsp.last, "full post not rejected")
  `DTTQ_ASSERT_NOW(a_no_insert_full, ctl.insert, !full && !ctl.pop, "insert into full chain or during pop")

endmodule

// ===== rtl/core/dttq_cell.sv =====
// one cell of the sorted timer chain: holds one entry
// depends on dttq_pkg
module dttq_cell import dttq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  slot_t      left_slot,
  input  logic       left_after,
  input  slot_t      right_slot,
  output slot_t      slot,
  output logic       after
);

  logic   valid_r, valid_nxt;
  entry_t data_r, data_nxt;

  // entry stays ahead of a new post with an equal or later due time
  assign after = valid_r && (data_r.due <= ctl.new_entry.due);
  assign slot  = '{valid: valid_r, data: data_r};

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.insert && !after) begin
      if (left_after) begin
        valid_nxt = 1'b1;
        data_nxt  = ctl.new_entry;
      end else begin
        valid_nxt = left_slot.valid;
        data_nxt  = left_slot.data;
      end
    end else if (ctl.pop) begin
      valid_nxt = right_slot.valid;
      data_nxt  = right_slot.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/core/dttq_chain.sv =====
// row of timer cells kept sorted by due time, head at cell 0
// depends on dttq_pkg and dttq_cell
module dttq_chain import dttq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  output slot_t      head,
  output slot_t      second,
  output logic       full
);

  slot_t slots [QUEUE_DEPTH];
  logic  afters [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_a;

    if (i == 0) begin : g_first
      assign left_s = '{valid: 1'b1, data: ctl.new_entry};
      assign left_a = 1'b1;
    end else begin : g_inner
      assign left_s = slots[i-1];
      assign left_a = afters[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_mid
      assign right_s = slots[i+1];
    end

    dttq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_slot  (left_s),
      .left_after (left_a),
      .right_slot (right_s),
      .slot       (slots[i]),
      .after      (afters[i])
    );
  end

  assign head   = slots[0];
  assign second = slots[1];
  assign full   = slots[QUEUE_DEPTH-1].valid;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench for the delayed task timer queue: directed and random post/poll traffic,
// with a cycle-free predictor that checks every released or rejected request in order
// depends on dttq_pkg and delayed_task_timer_queue_unit
module tb;
  import dttq_pkg::*;

  localparam int unsigned MAX_RELEASE  = 16;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam longint unsigned TIMEOUT_NS = 5_000_000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  logic [TIME_W-1:0] wall_ms = '0;

  entry_t            timer_entries [QUEUE_DEPTH];
  int unsigned       timer_count = 0;
  logic [SEQ_W-1:0]  seq_counter = '0;
  out_rsp_t          expected_releases [$];

  delayed_task_timer_queue_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bit comes_first(input entry_t a, input entry_t b);
    logic [SEQ_W-1:0] age_a;
    logic [SEQ_W-1:0] age_b;
    age_a = seq_counter - a.seq;
    age_b = seq_counter - b.seq;
    if (a.due != b.due) return a.due < b.due;
    return age_a > age_b;
  endfunction

  function automatic void predict_release(input in_req_t req);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] due;
    out_rsp_t          rsp;
    int unsigned       best;
    int unsigned       n;
    bit                done;
    if (req.command == CMD_POST) begin
      sum = {1'b0, req.now_ms} + {1'b0, req.delay_ms};
      due = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      if (timer_count >= QUEUE_DEPTH) begin
        rsp.status          = STATUS_REJECTED;
        rsp.released_handle = req.task_handle;
        rsp.released_seq    = '0;
        rsp.last            = 1'b1;
        expected_releases.push_back(rsp);
      end else begin
        timer_entries[timer_count].due    = due;
        timer_entries[timer_count].seq    = seq_counter;
        timer_entries[timer_count].handle = req.task_handle;
        timer_count++;
        seq_counter++;
      end
    end else begin
      n = 0;
      done = 1'b0;
      while (!done && n < MAX_RELEASE && timer_count > 0) begin
        best = 0;
        for (int unsigned i = 1; i < timer_count; i++) begin
          if (comes_first(timer_entries[i], timer_entries[best])) best = i;
        end
        if (timer_entries[best].due > req.now_ms) begin
          done = 1'b1;
        end else begin
          rsp.status          = STATUS_RELEASED;
          rsp.released_handle = timer_entries[best].handle;
          rsp.released_seq    = timer_entries[best].seq;
          rsp.last            = 1'b0;
          expected_releases.push_back(rsp);
          n++;
          timer_count--;
          timer_entries[best] = timer_entries[timer_count];
        end
      end
      if (n > 0) expected_releases[expected_releases.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_releases.size() == 0) begin
        report_mismatch("unexpected result seq", out_rsp.released_seq, '0);
      end else begin
        if (out_rsp.status !== expected_releases[0].status)
          report_mismatch("status", 32'(out_rsp.status),
                          32'(expected_releases[0].status));
        if (out_rsp.released_handle !== expected_releases[0].released_handle)
          report_mismatch("released_handle", 32'(out_rsp.released_handle),
                          32'(expected_releases[0].released_handle));
        if (out_rsp.released_seq !== expected_releases[0].released_seq)
          report_mismatch("released_seq", out_rsp.released_seq,
                          expected_releases[0].released_seq);
        if (out_rsp.last !== expected_releases[0].last)
          report_mismatch("last", 32'(out_rsp.last), 32'(expected_releases[0].last));
        void'(expected_releases.pop_front());
      end
    end
  end

  // returns at the accepting edge with valid still high
  task automatic send_request(input logic cmd, input logic [TIME_W-1:0] now,
                              input logic [TIME_W-1:0] delay,
                              input logic [HANDLE_W-1:0] handle);
    in_req_t req;
    req.command     = cmd;
    req.now_ms      = now;
    req.delay_ms    = delay;
    req.task_handle = handle;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_release(req);
  endtask

  task automatic park_request_channel();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_release_drain();
    while (expected_releases.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_poll();
    send_request(CMD_POLL, '0, '0, '0);
  endtask

  task automatic test_due_extremes();
    send_request(CMD_POST, '0, '0, 8'h00);
    send_request(CMD_POST, '1, '1, 8'hFF);
    send_request(CMD_POST, 32'h8000_0000, 32'h7FFF_FFFF, 8'h5A);
    send_request(CMD_POLL, '0, '1, 8'hFF);
    send_request(CMD_POLL, '1, '0, 8'h00);
  endtask

  task automatic test_tie_order();
    send_request(CMD_POST, 32'd1000, 32'd20, 8'h11);
    send_request(CMD_POST, 32'd1010, 32'd10, 8'h22);
    send_request(CMD_POLL, 32'd1020, '0, '0);
  endtask

  task automatic test_full_queue();
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      send_request(CMD_POST, 32'd5000, 32'(QUEUE_DEPTH - i), 8'(8'hA0 + i));
    end
    send_request(CMD_POST, 32'd5000, 32'd1, 8'hC3);
    send_request(CMD_POLL, '1, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned item_total);
    int unsigned        pick;
    logic [TIME_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
    for (int unsigned k = 0; k < item_total; k++) begin
      if (k == item_total / 2) begin
        park_request_channel();
        wait_for_release_drain();
      end
      pick = $urandom_range(99);
      handle = HANDLE_W'($urandom);
      if ($urandom_range(39) == 0) wall_ms = $urandom;
      if (pick < 8) begin
        send_request(1'($urandom), $urandom, $urandom, handle);
      end else if (pick < 52) begin
        case ($urandom_range(19))
          0: delay = '1;
          1: delay = $urandom;
          default: delay = $urandom_range(40);
        endcase
        send_request(CMD_POST, wall_ms, delay, handle);
      end else begin
        wall_ms = wall_ms + $urandom_range(30);
        if ($urandom_range(19) == 0) send_request(CMD_POLL, '1, $urandom, handle);
        else send_request(CMD_POLL, wall_ms, $urandom, handle);
      end
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 54;
    test_empty_poll();
    test_due_extremes();
    test_tie_order();
    test_full_queue();
    test_random_traffic(160);
    send_idle_pct = 54;
    recv_idle_pct = 37;
    test_random_traffic(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(160);
    park_request_channel();
    wait_for_release_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
